[hw/rtl/tba_pkg.sv]
// tba_pkg: shared types, widths and constants of the temporal bandpass amplifier.
// Used by tba_state_ram and temporal_bandpass_amplifier_unit; depends on nothing.

package tba_pkg;

  // Field widths
  localparam int VALUE_W    = 20;
  localparam int INDEX_W    = 16;
  localparam int LEVEL_W    = 3;
  localparam int CHAN_W     = 2;
  localparam int WEIGHT_W   = 16;
  localparam int GAIN_W     = 14;
  localparam int STATE_W    = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Pyramid levels below this one are band levels; this one and above is the residual
  localparam int PYRAMID_LEVELS = 5;

  localparam int COEFF_SLOTS_DEFAULT = 65536;
  localparam int COEFF_SLOTS_MIN     = 64;

  // Slot = index mod slots, via quotient = (index * ceil(2^32 / slots)) >> 32
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 27;  // ceil(2^32 / COEFF_SLOTS_MIN) fits
  localparam int QPROD_W     = INDEX_W + RECIP_W;
  localparam int QUOT_W      = QPROD_W - RECIP_SHIFT;

  localparam int VAL_MAX = 524287;
  localparam int VAL_MIN = -524288;

  // Register reset values
  localparam logic [WEIGHT_W-1:0]      FAST_COEFF_RST  = 16'd26214;
  localparam logic [WEIGHT_W-1:0]      SLOW_COEFF_RST  = 16'd3277;
  localparam logic [WEIGHT_W-1:0]      CHROMA_GAIN_RST = 16'd6554;
  localparam logic signed [GAIN_W-1:0] GAIN_LEVEL_RST  = 14'sd5120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_COEFF   = 3'd0,
    CFG_SLOW_COEFF   = 3'd1,
    CFG_CHROMA_GAIN  = 3'd2,
    CFG_GAIN_ONE     = 3'd3,
    CFG_GAIN_TWO     = 3'd4,
    CFG_GAIN_THREE   = 3'd5,
    CFG_GAIN_FOUR    = 3'd6
  } cfg_reg_t;

  localparam logic [CHAN_W-1:0] CHAN_L = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_A = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_B = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = 3'd4;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO  = 3'd0;

  typedef struct packed {
    logic signed [VALUE_W-1:0] coeff_value;
    logic [INDEX_W-1:0]        coeff_index;
    logic [LEVEL_W-1:0]        band_level;
    logic [CHAN_W-1:0]         color_channel;
    logic                      first_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] motion_value;
    logic                      saturated;
  } out_item_t;

endpackage

[hw/rtl/tba_state_ram.sv]
// tba_state_ram: single-clock RAM for the per-slot lowpass states,
// one write port and one read port with registered read data. Uses tba_pkg for defaults.

module tba_state_ram #(
  parameter int DEPTH  = tba_pkg::COEFF_SLOTS_DEFAULT,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 2 * tba_pkg::STATE_W
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read during write to the same address returns the old word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/temporal_bandpass_amplifier_unit.sv]
// temporal_bandpass_amplifier_unit: per-coefficient fast/slow IIR lowpass pair,
// band difference times level gain and chroma attenuation, rounded and saturated.
// Depends on tba_pkg and tba_state_ram.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one pyramid coefficient per item.
//   Output channel out_valid/out_stall/out_data returns one result per item, in order.
//   Items are taken when valid is high and stall is low; the receiver drives stall.
//   cfg_wr_en/cfg_index/cfg_data writes one register per cycle; the user must write
//   only while no item is in flight, which the block itself does not enforce.
// Pipeline: two stages form the slot index, one reads the state RAM, then update,
//   gain, multiply, round/saturate. Throughput: one item per cycle but for stalls.
//   The state RAM does read/modify/write per slot; an item whose slot matches either
//   of the two items just ahead of it waits at the RAM read until that write is done.
// Reset: valid bits and configuration registers return to defaults. The state RAM
//   is not cleared; a slot must see a first-frame item before it is filtered.
// Stall: while out_stall holds a result, the back end freezes; the two front
//   stages still fill, then in_stall rises.

module temporal_bandpass_amplifier_unit #(
  parameter int COEFF_SLOTS = tba_pkg::COEFF_SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tba_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tba_pkg::out_item_t                 out_data,
  input  logic                               cfg_wr_en,
  input  logic [tba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tba_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SLOT_W = $clog2(COEFF_SLOTS);
  localparam int SW     = tba_pkg::STATE_W;
  localparam int GW     = tba_pkg::GAIN_W;
  localparam int PROD_W = SW + 1 + tba_pkg::WEIGHT_W + 1;  // diff x weight
  localparam int EG_W   = GW + tba_pkg::WEIGHT_W;          // effective gain
  localparam int MP_W   = SW + 1 + EG_W;                   // band x effective gain
  localparam int RES_W  = MP_W - 32;
  localparam logic [tba_pkg::RECIP_W-1:0] SLOT_RECIP = tba_pkg::RECIP_W'(
    ((64'd1 << tba_pkg::RECIP_SHIFT) + 64'(COEFF_SLOTS) - 64'd1) / 64'(COEFF_SLOTS));
  localparam logic [31:0] SLOT_COUNT = 32'(COEFF_SLOTS);

  // ---------------- configuration registers ----------------
  logic [tba_pkg::WEIGHT_W-1:0] fast_w_r, slow_w_r, chroma_r;
  logic signed [GW-1:0]         gain1_r, gain2_r, gain3_r, gain4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_w_r <= tba_pkg::FAST_COEFF_RST;
      slow_w_r <= tba_pkg::SLOW_COEFF_RST;
      chroma_r <= tba_pkg::CHROMA_GAIN_RST;
      gain1_r  <= tba_pkg::GAIN_LEVEL_RST;
      gain2_r  <= tba_pkg::GAIN_LEVEL_RST;
      gain3_r  <= tba_pkg::GAIN_LEVEL_RST;
      gain4_r  <= tba_pkg::GAIN_LEVEL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tba_pkg::CFG_FAST_COEFF:  fast_w_r <= cfg_data;
        tba_pkg::CFG_SLOW_COEFF:  slow_w_r <= cfg_data;
        tba_pkg::CFG_CHROMA_GAIN: chroma_r <= cfg_data;
        tba_pkg::CFG_GAIN_ONE:    gain1_r  <= $signed(cfg_data[GW-1:0]);
        tba_pkg::CFG_GAIN_TWO:    gain2_r  <= $signed(cfg_data[GW-1:0]);
        tba_pkg::CFG_GAIN_THREE:  gain3_r  <= $signed(cfg_data[GW-1:0]);
        tba_pkg::CFG_GAIN_FOUR:   gain4_r  <= $signed(cfg_data[GW-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic va_r, vb_r, v1_r, v2_r, v3_r, v4_r, ov_r;
  logic back_en, issue, hazard, b_free, a_go, a_free, a_load;

  tba_pkg::in_item_t           a_item_r, b_item_r;
  logic [tba_pkg::QUOT_W-1:0]  a_quot_r;
  logic [SLOT_W-1:0]           b_slot_r, s1_slot_r, s2_slot_r;

  // Back end (RAM read onward) moves as one block whenever the output can take a result
  assign back_en = !ov_r || !out_stall;
  // Slot still has a pending write in stage 1 or stage 2
  assign hazard  = (v1_r && (s1_slot_r == b_slot_r)) || (v2_r && (s2_slot_r == b_slot_r));
  assign issue   = vb_r && !hazard && back_en;
  assign b_free  = !vb_r || issue;
  assign a_go    = va_r && b_free;
  assign a_free  = !va_r || b_free;
  assign in_stall = !a_free;
  assign a_load  = in_valid && a_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (a_load) begin
        va_r <= 1'b1;
      end else if (a_go) begin
        va_r <= 1'b0;
      end
      if (a_go) begin
        vb_r <= 1'b1;
      end else if (issue) begin
        vb_r <= 1'b0;
      end
      if (back_en) begin
        v1_r <= issue;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
        ov_r <= v4_r;
      end
    end
  end

  // ---------------- stage a/b: slot = index mod COEFF_SLOTS ----------------
  logic [tba_pkg::QPROD_W-1:0] in_qprod;
  logic [31:0]                 a_rem;

  assign in_qprod = tba_pkg::QPROD_W'(in_data.coeff_index) * tba_pkg::QPROD_W'(SLOT_RECIP);
  assign a_rem    = 32'(a_item_r.coeff_index) - 32'(a_quot_r) * SLOT_COUNT;

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_item_r <= in_data;
      a_quot_r <= in_qprod[tba_pkg::QPROD_W-1:tba_pkg::RECIP_SHIFT];
    end
    if (a_go) begin
      b_item_r <= a_item_r;
      b_slot_r <= a_rem[SLOT_W-1:0];
    end
  end

  // ---------------- state RAM ----------------
  logic [2*SW-1:0] rd_data, wr_data;
  logic            wr_en;

  tba_state_ram #(
    .DEPTH  (COEFF_SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (2 * SW)
  ) u_state_ram (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (b_slot_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s2_slot_r),
    .wr_data (wr_data)
  );

  // ---------------- stage 1: differences times weights ----------------
  tba_pkg::in_item_t     s1_item_r;
  logic signed [SW-1:0]  s1_target, s1_old_f, s1_old_s;
  logic signed [SW:0]    s1_diff_f, s1_diff_s;
  logic signed [PROD_W-1:0] s1_prod_f, s1_prod_s;
  logic signed [GW-1:0]  s1_gain;
  logic                  s1_wr, s1_zero, s1_chroma;

  always_ff @(posedge clk) begin
    if (back_en) begin
      s1_item_r <= b_item_r;
      s1_slot_r <= b_slot_r;
    end
  end

  assign s1_target = $signed({s1_item_r.coeff_value, 8'd0});
  assign s1_old_f  = $signed(rd_data[2*SW-1:SW]);
  assign s1_old_s  = $signed(rd_data[SW-1:0]);
  assign s1_diff_f = (SW+1)'(s1_target) - (SW+1)'(s1_old_f);
  assign s1_diff_s = (SW+1)'(s1_target) - (SW+1)'(s1_old_s);
  assign s1_prod_f = PROD_W'(s1_diff_f) * PROD_W'($signed({1'b0, fast_w_r}));
  assign s1_prod_s = PROD_W'(s1_diff_s) * PROD_W'($signed({1'b0, slow_w_r}));

  always_comb begin
    unique case (s1_item_r.band_level)
      tba_pkg::LEVEL_ONE:   s1_gain = gain1_r;
      tba_pkg::LEVEL_TWO:   s1_gain = gain2_r;
      tba_pkg::LEVEL_THREE: s1_gain = gain3_r;
      tba_pkg::LEVEL_FOUR:  s1_gain = gain4_r;
      default:              s1_gain = '0;
    endcase
  end

  // Residual level keeps its states after the first frame
  assign s1_wr     = s1_item_r.first_frame ||
                     (32'(s1_item_r.band_level) < tba_pkg::PYRAMID_LEVELS);
  assign s1_zero   = s1_item_r.first_frame || (s1_item_r.band_level == tba_pkg::LEVEL_ZERO) ||
                     (32'(s1_item_r.band_level) >= tba_pkg::PYRAMID_LEVELS);
  assign s1_chroma = (s1_item_r.color_channel == tba_pkg::CHAN_A) ||
                     (s1_item_r.color_channel == tba_pkg::CHAN_B);

  // ---------------- stage 2: state update, RAM write, effective gain ----------------
  logic signed [PROD_W-1:0] s2_prod_f_r, s2_prod_s_r, s2_rnd_f, s2_rnd_s;
  logic signed [SW-1:0]     s2_old_f_r, s2_old_s_r, s2_target_r, s2_new_f, s2_new_s;
  logic signed [GW-1:0]     s2_gain_r;
  logic                     s2_first_r, s2_wr_r, s2_zero_r, s2_chroma_r;
  logic signed [EG_W:0]     s2_gain_chroma;
  logic signed [EG_W-1:0]   s2_eff_gain;

  always_ff @(posedge clk) begin
    if (back_en) begin
      s2_prod_f_r <= s1_prod_f;
      s2_prod_s_r <= s1_prod_s;
      s2_old_f_r  <= s1_old_f;
      s2_old_s_r  <= s1_old_s;
      s2_target_r <= s1_target;
      s2_gain_r   <= s1_gain;
      s2_first_r  <= s1_item_r.first_frame;
      s2_wr_r     <= s1_wr;
      s2_zero_r   <= s1_zero;
      s2_chroma_r <= s1_chroma;
      s2_slot_r   <= s1_slot_r;
    end
  end

  // Round half up: floor((p + 2^15) / 2^16)
  assign s2_rnd_f = (s2_prod_f_r + PROD_W'(32768)) >>> 16;
  assign s2_rnd_s = (s2_prod_s_r + PROD_W'(32768)) >>> 16;
  assign s2_new_f = s2_first_r ? s2_target_r : s2_old_f_r + s2_rnd_f[SW-1:0];
  assign s2_new_s = s2_first_r ? s2_target_r : s2_old_s_r + s2_rnd_s[SW-1:0];

  assign wr_en   = back_en && v2_r && s2_wr_r;
  assign wr_data = {s2_new_f, s2_new_s};

  // Lightness uses gain * 2^16 so both cases share the >> 32 at the end
  assign s2_gain_chroma = (EG_W+1)'(s2_gain_r) * (EG_W+1)'($signed({1'b0, chroma_r}));
  assign s2_eff_gain    = s2_chroma_r ? s2_gain_chroma[EG_W-1:0] : $signed({s2_gain_r, 16'd0});

  // ---------------- stage 3: band difference times gain ----------------
  logic signed [SW-1:0]   s3_new_f_r, s3_new_s_r;
  logic signed [EG_W-1:0] s3_gain_r;
  logic                   s3_zero_r;
  logic signed [SW:0]     s3_band;
  logic signed [MP_W-1:0] s3_prod;

  always_ff @(posedge clk) begin
    if (back_en) begin
      s3_new_f_r <= s2_new_f;
      s3_new_s_r <= s2_new_s;
      s3_gain_r  <= s2_eff_gain;
      s3_zero_r  <= s2_zero_r;
    end
  end

  assign s3_band = (SW+1)'(s3_new_f_r) - (SW+1)'(s3_new_s_r);
  assign s3_prod = MP_W'(s3_band) * MP_W'(s3_gain_r);

  // ---------------- stage 4: round and saturate into the output register ----------------
  logic signed [MP_W-1:0]  s4_prod_r, s4_sum;
  logic                    s4_zero_r;
  logic signed [RES_W-1:0] s4_res;
  tba_pkg::out_item_t      s4_out, out_r;

  always_ff @(posedge clk) begin
    if (back_en) begin
      s4_prod_r <= s3_prod;
      s4_zero_r <= s3_zero_r;
    end
  end

  assign s4_sum = s4_prod_r + (MP_W'(1) <<< 31);
  assign s4_res = RES_W'(s4_sum >>> 32);

  always_comb begin
    s4_out.motion_value = s4_res[tba_pkg::VALUE_W-1:0];
    s4_out.saturated    = 1'b0;
    priority if (s4_zero_r) begin
      s4_out.motion_value = '0;
    end else if (s4_res > RES_W'(tba_pkg::VAL_MAX)) begin
      s4_out.motion_value = tba_pkg::VALUE_W'(tba_pkg::VAL_MAX);
      s4_out.saturated    = 1'b1;
    end else if (s4_res < RES_W'(tba_pkg::VAL_MIN)) begin
      s4_out.motion_value = tba_pkg::VALUE_W'(tba_pkg::VAL_MIN);
      s4_out.saturated    = 1'b1;
    end else begin
      s4_out.saturated    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      out_r <= s4_out;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

  // ---------------- assertions ----------------
  // A read never races a write of the same slot
  a_no_rw_race: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !(wr_en && (s2_slot_r == b_slot_r)))
    else $error("state RAM read issued while same slot is written");

  // The two stages ahead of the write never hold the same slot
  a_distinct_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r) |-> (s1_slot_r != s2_slot_r))
    else $error("two in-flight items share a slot");

  // Saturation flag only with a clipped value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_r.saturated) |->
      ((out_r.motion_value == tba_pkg::VALUE_W'(tba_pkg::VAL_MAX)) ||
       (out_r.motion_value == tba_pkg::VALUE_W'(tba_pkg::VAL_MIN))))
    else $error("saturated flag without clipped value");

  // An item held at the RAM read while the back end runs has stage 1 or stage 2 valid
  a_hazard_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && back_en && !issue) |-> (v1_r || v2_r))
    else $error("item held at RAM read without a pending write");

endmodule
